// File: hw/rtl/esac_pkg.sv
package esac_pkg;

  // Register indexes on the configuration port (byte address is 4 * index).
  localparam logic [2:0] REG_CAPACITY  = 3'd0;
  localparam logic [2:0] REG_FLOOR     = 3'd1;
  localparam logic [2:0] REG_LOW_ENE   = 3'd2;
  localparam logic [2:0] REG_FULL_ENE  = 3'd3;
  localparam logic [2:0] REG_LOW_LAT   = 3'd4;
  localparam logic [2:0] REG_FULL_LAT  = 3'd5;
  localparam logic [2:0] REG_LAT_LIMIT = 3'd6;
  localparam logic [2:0] REG_GAIN      = 3'd7;

  // Reset values of the registers.
  localparam logic [23:0] RST_CAPACITY  = 24'd5120;
  localparam logic [23:0] RST_FLOOR     = 24'd1280;
  localparam logic [23:0] RST_LOW_ENE   = 24'd410;
  localparam logic [23:0] RST_FULL_ENE  = 24'd973;
  localparam logic [23:0] RST_LOW_LAT   = 24'd358;
  localparam logic [23:0] RST_FULL_LAT  = 24'd90;
  localparam logic [23:0] RST_LAT_LIMIT = 24'd4608;
  localparam logic [15:0] RST_GAIN      = 16'd12780;

  // Action codes.
  localparam logic [1:0] ACT_DEFER = 2'd0;
  localparam logic [1:0] ACT_LOW   = 2'd1;
  localparam logic [1:0] ACT_FULL  = 2'd2;

  // 0.08 in Q0.24, and the one-second defer increment in Q16.8.
  localparam logic [20:0] LAT_COEF = 21'd1342177;
  localparam logic [23:0] ONE_SEC  = 24'd256;

  // Penalties in Q.16.
  localparam logic [25:0] PEN_DEFER = 26'd65536;
  localparam logic [25:0] PEN_LATE  = 26'd65536000;
  localparam logic [25:0] PEN_LOW   = 26'd16384;
  localparam logic [25:0] PEN_FULL  = 26'd0;

  localparam logic [41:0] COST_MAX = 42'h3FF_FFFF_FFFF;

  // Evaluation of one action.
  typedef struct packed {
    logic        ok;
    logic [23:0] proj_level;
    logic [41:0] cost;
  } cand_t;

endpackage

// File: hw/rtl/esac_cand.sv
module esac_cand (
  input  logic [26:0]    avail,
  input  logic [23:0]    action_energy,
  input  logic [23:0]    capacity,
  input  logic [23:0]    floor_level,
  input  logic [39:0]    price_term,
  input  logic [28:0]    lat_term,
  input  logic [25:0]    penalty,
  output esac_pkg::cand_t cand
);

  logic signed [27:0] diff;
  logic signed [27:0] clamped;
  logic        [42:0] cost_sum;

  // The projection is exact and signed; it is then capped at the capacity.
  assign diff    = $signed({1'b0, avail}) - $signed({4'b0, action_energy});
  assign clamped = (diff > $signed({4'b0, capacity})) ? $signed({4'b0, capacity}) : diff;

  assign cost_sum = 43'(price_term) + 43'(lat_term) + 43'(penalty);

  always_comb begin
    cand.ok         = (clamped >= $signed({4'b0, floor_level}));
    cand.proj_level = clamped[23:0];
    cand.cost       = (cost_sum > 43'(esac_pkg::COST_MAX)) ? esac_pkg::COST_MAX
                                                           : cost_sum[41:0];
  end

endmodule

// File: hw/rtl/energy_safe_action_chooser_unit.sv
// Energy-safe action chooser.
// Input items arrive on the in_ stream (in_tvalid/in_tready/in_tdata) and carry the
// battery level, the harvested energy, the age of a deferred task and the energy price.
// For every item the block scores defer, low-power and full-power inference, drops any
// action that would leave the battery below the energy floor, and returns one result
// item on the out_ stream with the cheapest kept action. Ties keep the earlier action.
// When no action is feasible the result is all zeros with the feasible flag in tuser low.
// The eight tuning registers sit on an APB-style port (cfg_); write them while the block
// is idle. pready is always high and reads return the stored value.
// The datapath is three register stages deep: an input register, a register after the
// multipliers (harvest, price and latency products), and the result register after the
// per-action compare and select; out_tvalid is that register's valid. One item can be
// taken every cycle unless out_tready stalls. Each stage advances when the next one
// is empty or advancing, so a stall on out_tready fills the stages and then drops
// in_tready; nothing is lost or repeated. Reset (rst_n low, synchronous) empties all
// stages and returns the registers to their default values.
module energy_safe_action_chooser_unit (
  input  logic        clk,
  input  logic        rst_n,
  // APB-style configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  // in_tdata: battery_level[23:0], harvest_amount[47:24], pending_age[71:48],
  //           energy_price[87:72]
  input  logic [87:0] in_tdata,
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_tdata: chosen_action[1:0], projected_energy[25:2], action_latency[49:26],
  //            action_cost[91:50], zero pad[95:92]
  output logic [95:0] out_tdata,
  // out_tuser: feasible[0]
  output logic [0:0]  out_tuser
);

  // ---------------------------------------------------------------- registers
  logic [23:0] capacity_r, floor_r, low_ene_r, full_ene_r;
  logic [23:0] low_lat_r, full_lat_r, lat_limit_r;
  logic [15:0] gain_r;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r  <= esac_pkg::RST_CAPACITY;
      floor_r     <= esac_pkg::RST_FLOOR;
      low_ene_r   <= esac_pkg::RST_LOW_ENE;
      full_ene_r  <= esac_pkg::RST_FULL_ENE;
      low_lat_r   <= esac_pkg::RST_LOW_LAT;
      full_lat_r  <= esac_pkg::RST_FULL_LAT;
      lat_limit_r <= esac_pkg::RST_LAT_LIMIT;
      gain_r      <= esac_pkg::RST_GAIN;
    end else if (cfg_wr) begin
      case (cfg_idx)
        esac_pkg::REG_CAPACITY:  capacity_r  <= cfg_pwdata[23:0];
        esac_pkg::REG_FLOOR:     floor_r     <= cfg_pwdata[23:0];
        esac_pkg::REG_LOW_ENE:   low_ene_r   <= cfg_pwdata[23:0];
        esac_pkg::REG_FULL_ENE:  full_ene_r  <= cfg_pwdata[23:0];
        esac_pkg::REG_LOW_LAT:   low_lat_r   <= cfg_pwdata[23:0];
        esac_pkg::REG_FULL_LAT:  full_lat_r  <= cfg_pwdata[23:0];
        esac_pkg::REG_LAT_LIMIT: lat_limit_r <= cfg_pwdata[23:0];
        esac_pkg::REG_GAIN:      gain_r      <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      esac_pkg::REG_CAPACITY:  cfg_prdata = {8'b0, capacity_r};
      esac_pkg::REG_FLOOR:     cfg_prdata = {8'b0, floor_r};
      esac_pkg::REG_LOW_ENE:   cfg_prdata = {8'b0, low_ene_r};
      esac_pkg::REG_FULL_ENE:  cfg_prdata = {8'b0, full_ene_r};
      esac_pkg::REG_LOW_LAT:   cfg_prdata = {8'b0, low_lat_r};
      esac_pkg::REG_FULL_LAT:  cfg_prdata = {8'b0, full_lat_r};
      esac_pkg::REG_LAT_LIMIT: cfg_prdata = {8'b0, lat_limit_r};
      esac_pkg::REG_GAIN:      cfg_prdata = {16'b0, gain_r};
      default:                 cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- flow control
  // Each stage loads when it is empty or the stage after it is moving.
  logic s1_valid_r, s2_valid_r, out_valid_r;
  logic adv1, adv2, adv3;

  assign adv3      = !out_valid_r || out_tready;
  assign adv2      = !s2_valid_r || adv3;
  assign adv1      = !s1_valid_r || adv2;
  assign in_tready = adv1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv1) s1_valid_r  <= in_tvalid;
      if (adv2) s2_valid_r  <= s1_valid_r;
      if (adv3) out_valid_r <= s2_valid_r;
    end
  end

  // ---------------------------------------------------------------- stage 1: input
  logic [23:0] battery_r, harvest_r, age_r;
  logic [15:0] price_r;

  always_ff @(posedge clk) begin
    if (adv1 && in_tvalid) begin
      battery_r <= in_tdata[23:0];
      harvest_r <= in_tdata[47:24];
      age_r     <= in_tdata[71:48];
      price_r   <= in_tdata[87:72];
    end
  end

  // ---------------------------------------------------------------- stage 2: products
  logic [39:0] harv_prod;
  logic [24:0] age_inc;
  logic [23:0] lat_def_nxt;
  logic [44:0] lprod_def, lprod_low, lprod_full;

  assign harv_prod   = 40'(gain_r) * 40'(harvest_r);
  assign age_inc     = 25'(age_r) + 25'(esac_pkg::ONE_SEC);
  // The defer latency saturates at the top of the 24-bit range.
  assign lat_def_nxt = age_inc[24] ? '1 : age_inc[23:0];
  assign lprod_def   = 45'(lat_def_nxt) * 45'(esac_pkg::LAT_COEF);
  assign lprod_low   = 45'(low_lat_r) * 45'(esac_pkg::LAT_COEF);
  assign lprod_full  = 45'(full_lat_r) * 45'(esac_pkg::LAT_COEF);

  logic [26:0] avail_r;
  logic [39:0] pterm_low_r, pterm_full_r;
  logic [28:0] lterm_def_r, lterm_low_r, lterm_full_r;
  logic [23:0] lat_def_r;
  logic        late_r;

  always_ff @(posedge clk) begin
    if (adv2 && s1_valid_r) begin
      avail_r      <= 27'(battery_r) + 27'(harv_prod[39:14]);
      pterm_low_r  <= 40'(price_r) * 40'(low_ene_r);
      pterm_full_r <= 40'(price_r) * 40'(full_ene_r);
      lterm_def_r  <= lprod_def[44:16];
      lterm_low_r  <= lprod_low[44:16];
      lterm_full_r <= lprod_full[44:16];
      lat_def_r    <= lat_def_nxt;
      late_r       <= (age_r >= lat_limit_r);
    end
  end

  // ---------------------------------------------------------------- stage 3: select
  esac_pkg::cand_t cand_def, cand_low, cand_full;

  esac_cand u_cand_def (
    .avail         (avail_r),
    .action_energy (24'd0),
    .capacity      (capacity_r),
    .floor_level   (floor_r),
    .price_term    (40'd0),
    .lat_term      (lterm_def_r),
    .penalty       (late_r ? esac_pkg::PEN_LATE : esac_pkg::PEN_DEFER),
    .cand          (cand_def)
  );

  esac_cand u_cand_low (
    .avail         (avail_r),
    .action_energy (low_ene_r),
    .capacity      (capacity_r),
    .floor_level   (floor_r),
    .price_term    (pterm_low_r),
    .lat_term      (lterm_low_r),
    .penalty       (esac_pkg::PEN_LOW),
    .cand          (cand_low)
  );

  esac_cand u_cand_full (
    .avail         (avail_r),
    .action_energy (full_ene_r),
    .capacity      (capacity_r),
    .floor_level   (floor_r),
    .price_term    (pterm_full_r),
    .lat_term      (lterm_full_r),
    .penalty       (esac_pkg::PEN_FULL),
    .cand          (cand_full)
  );

  logic        found;
  logic [1:0]  best_act;
  logic [23:0] best_next, best_lat;
  logic [41:0] best_cost;

  // Strict less-than keeps the earlier action on a tie.
  always_comb begin
    found     = 1'b0;
    best_act  = esac_pkg::ACT_DEFER;
    best_next = '0;
    best_lat  = '0;
    best_cost = '0;
    if (cand_def.ok) begin
      found     = 1'b1;
      best_next = cand_def.proj_level;
      best_lat  = lat_def_r;
      best_cost = cand_def.cost;
    end
    if (cand_low.ok && (!found || cand_low.cost < best_cost)) begin
      found     = 1'b1;
      best_act  = esac_pkg::ACT_LOW;
      best_next = cand_low.proj_level;
      best_lat  = low_lat_r;
      best_cost = cand_low.cost;
    end
    if (cand_full.ok && (!found || cand_full.cost < best_cost)) begin
      found     = 1'b1;
      best_act  = esac_pkg::ACT_FULL;
      best_next = cand_full.proj_level;
      best_lat  = full_lat_r;
      best_cost = cand_full.cost;
    end
  end

  logic [95:0] out_data_r;
  logic        out_feasible_r;

  always_ff @(posedge clk) begin
    if (adv3 && s2_valid_r) begin
      out_data_r     <= {4'b0, best_cost, best_lat, best_next, best_act};
      out_feasible_r <= found;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_feasible_r;

`ifndef SYNTH
  // An infeasible result carries an all-zero payload.
  a_infeasible_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (out_tdata == '0))
    else $error("infeasible result with nonzero payload");

  // A feasible result never projects below the energy floor.
  a_floor_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tdata[25:2] >= floor_r))
    else $error("chosen action drops below energy floor");

  // An item in the input stage that may advance reaches the product stage.
  a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && adv2) |=> s2_valid_r)
    else $error("item lost between input and product stages");
`endif

endmodule

// File: sim/energy_safe_action_chooser_unit_tb.sv
module energy_safe_action_chooser_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Generous cycle budget for a slow run of about 430 items with the longest input gaps
  // and output stalls, plus eleven register reloads.
  localparam int CYCLE_LIMIT = 100000;
  // Cycles a result can still be in flight after its item is taken.
  localparam int PIPE_DEPTH = 4;
  localparam int RANDOM_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 50;

  // One input item, packed so that battery_level lands in the lowest bits of in_tdata.
  typedef struct packed {
    logic [15:0] price;
    logic [23:0] age;
    logic [23:0] harvest;
    logic [23:0] battery;
  } sample_t;

  // One result item as {out_tuser, out_tdata}: the action code sits in the lowest bits
  // and the feasible flag from tuser on top.
  typedef struct packed {
    logic        feasible;
    logic [3:0]  pad;
    logic [41:0] cost;
    logic [23:0] latency;
    logic [23:0] energy;
    logic [1:0]  action;
  } decision_t;

  // Keeps its own copy of the tuning registers, predicts the decision for every item
  // taken by the block and compares each result against the oldest prediction.
  class chooser_scoreboard;
    logic [23:0] capacity;
    logic [23:0] floor_lvl;
    logic [23:0] low_energy;
    logic [23:0] full_energy;
    logic [23:0] low_lat;
    logic [23:0] full_lat;
    logic [23:0] lat_limit;
    logic [15:0] gain;
    decision_t   pending_choices[$];
    int unsigned errors;

    function new();
      capacity    = esac_pkg::RST_CAPACITY;
      floor_lvl   = esac_pkg::RST_FLOOR;
      low_energy  = esac_pkg::RST_LOW_ENE;
      full_energy = esac_pkg::RST_FULL_ENE;
      low_lat     = esac_pkg::RST_LOW_LAT;
      full_lat    = esac_pkg::RST_FULL_LAT;
      lat_limit   = esac_pkg::RST_LAT_LIMIT;
      gain        = esac_pkg::RST_GAIN;
      errors      = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        esac_pkg::REG_CAPACITY:  capacity    = val[23:0];
        esac_pkg::REG_FLOOR:     floor_lvl   = val[23:0];
        esac_pkg::REG_LOW_ENE:   low_energy  = val[23:0];
        esac_pkg::REG_FULL_ENE:  full_energy = val[23:0];
        esac_pkg::REG_LOW_LAT:   low_lat     = val[23:0];
        esac_pkg::REG_FULL_LAT:  full_lat    = val[23:0];
        esac_pkg::REG_LAT_LIMIT: lat_limit   = val[23:0];
        esac_pkg::REG_GAIN:      gain        = val[15:0];
        default: ;
      endcase
    endfunction

    // Scores defer, low power and full power in that order and keeps the cheapest
    // action whose projected energy stays at or above the floor.
    function decision_t choose_action(sample_t s);
      longint          avail;
      longint          nxt;
      longint unsigned cost;
      longint unsigned best_cost;
      longint unsigned spend[3];
      longint unsigned lat[3];
      longint unsigned pen[3];
      logic [1:0]      act_code[3];
      decision_t       d;
      bit              found;
      d = '0;
      found = 1'b0;
      best_cost = 0;
      // Battery plus the harvest scaled by the Q2.14 gain, truncated back to Q.8.
      avail = longint'(s.battery) + longint'((64'(gain) * 64'(s.harvest)) >> 14);
      act_code[0] = esac_pkg::ACT_DEFER;
      spend[0] = 0;
      lat[0] = 64'(s.age) + 64'(esac_pkg::ONE_SEC);
      if (lat[0] > 64'hFF_FFFF) lat[0] = 64'hFF_FFFF;
      pen[0] = (s.age >= lat_limit) ? 64'(esac_pkg::PEN_LATE) : 64'(esac_pkg::PEN_DEFER);
      act_code[1] = esac_pkg::ACT_LOW;
      spend[1] = 64'(low_energy);
      lat[1] = 64'(low_lat);
      pen[1] = 64'(esac_pkg::PEN_LOW);
      act_code[2] = esac_pkg::ACT_FULL;
      spend[2] = 64'(full_energy);
      lat[2] = 64'(full_lat);
      pen[2] = 64'(esac_pkg::PEN_FULL);
      for (int k = 0; k < 3; k++) begin
        nxt = avail - longint'(spend[k]);
        if (nxt > longint'(capacity)) nxt = longint'(capacity);
        if (nxt < longint'(floor_lvl)) continue;
        cost = 64'(s.price) * spend[k] + ((lat[k] * 64'(esac_pkg::LAT_COEF)) >> 16)
               + pen[k];
        if (cost > 64'(esac_pkg::COST_MAX)) cost = 64'(esac_pkg::COST_MAX);
        // A strict compare keeps the earlier action on a tie.
        if (!found || cost < best_cost) begin
          found = 1'b1;
          best_cost = cost;
          d.action = act_code[k];
          d.energy = nxt[23:0];
          d.latency = lat[k][23:0];
          d.cost = cost[41:0];
          d.feasible = 1'b1;
        end
      end
      return d;
    endfunction

    function void note_item(sample_t s);
      pending_choices.push_back(choose_action(s));
    endfunction

    function void compare(string field, longint unsigned want, longint unsigned got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_result(decision_t got);
      decision_t want;
      if (pending_choices.size() == 0) begin
        $display("%0t: unexpected result item, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = pending_choices.pop_front();
      compare("chosen_action", want.action, got.action);
      compare("projected_energy", want.energy, got.energy);
      compare("action_latency", want.latency, got.latency);
      compare("action_cost", want.cost, got.cost);
      compare("feasible", want.feasible, got.feasible);
      compare("tdata padding", want.pad, got.pad);
    endfunction
  endclass

  logic        clk;
  logic        rst_n       = 1'b0;
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [4:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  // in_tdata: battery_level, harvest_amount, pending_age, energy_price (lowest first)
  logic [87:0] in_tdata    = '0;
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  // out_tdata: chosen_action, projected_energy, action_latency, action_cost, zero pad
  logic [95:0] out_tdata;
  // out_tuser: feasible
  logic [0:0]  out_tuser;

  // Idling knobs for the two sides; they change only between phases.
  bit          idle_in  = 1'b1;
  bit          idle_out = 1'b1;
  int unsigned stall_left = 0;

  // Register values to load in the next reconfiguration, indexed by register.
  logic [31:0] setting[8];

  chooser_scoreboard sb = new();

  energy_safe_action_chooser_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // The receiver drops tready in random bursts while output idling is on.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (idle_out && $urandom_range(0, 4) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 7);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Every result item taken at this edge is checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_result({out_tuser, out_tdata});
    end
  end

  // A hung handshake ends the run here.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Verification failed");
    $finish;
  end

  function automatic sample_t sample_of(logic [23:0] battery, logic [23:0] harvest,
                                        logic [23:0] age, logic [15:0] price);
    sample_t s;
    s.battery = battery;
    s.harvest = harvest;
    s.age = age;
    s.price = price;
    return s;
  endfunction

  // Draws a 24-bit level: fully random, small, close to a pivot, the pivot itself,
  // or one of the two extremes. Pivots are the thresholds where the decision flips.
  function automatic logic [23:0] pick_level(logic [23:0] pivot);
    longint v;
    case ($urandom_range(0, 4))
      0: return 24'($urandom());
      1: return 24'($urandom_range(0, 4096));
      2: begin
        v = longint'(pivot) + longint'($urandom_range(0, 600)) - 300;
        if (v < 0) v = 0;
        if (v > 16777215) v = 16777215;
        return v[23:0];
      end
      3: return pivot;
      default: return $urandom_range(0, 1) ? 24'hFF_FFFF : 24'h0;
    endcase
  endfunction

  // Random items aim the battery at the floor, or at the floor plus one of the action
  // energies, so that actions drop in and out of the feasible set. The age clusters
  // around the latency limit to exercise the late defer penalty.
  function automatic sample_t random_sample();
    sample_t     s;
    logic [23:0] pivot;
    case ($urandom_range(0, 2))
      0:       pivot = sb.floor_lvl;
      1:       pivot = sb.floor_lvl + sb.low_energy;
      default: pivot = sb.floor_lvl + sb.full_energy;
    endcase
    s.battery = pick_level(pivot);
    s.harvest = pick_level(24'h0);
    s.age = pick_level(sb.lat_limit);
    s.price = $urandom_range(0, 1) ? 16'($urandom()) : 16'($urandom_range(0, 512));
    return s;
  endfunction

  // Fills the next register set: sometimes the reset values, otherwise small values
  // that keep decisions contested, with a fully random value now and then.
  function automatic void random_setting();
    logic [23:0] cap;
    if ($urandom_range(0, 3) == 0) begin
      setting[esac_pkg::REG_CAPACITY]  = 32'(esac_pkg::RST_CAPACITY);
      setting[esac_pkg::REG_FLOOR]     = 32'(esac_pkg::RST_FLOOR);
      setting[esac_pkg::REG_LOW_ENE]   = 32'(esac_pkg::RST_LOW_ENE);
      setting[esac_pkg::REG_FULL_ENE]  = 32'(esac_pkg::RST_FULL_ENE);
      setting[esac_pkg::REG_LOW_LAT]   = 32'(esac_pkg::RST_LOW_LAT);
      setting[esac_pkg::REG_FULL_LAT]  = 32'(esac_pkg::RST_FULL_LAT);
      setting[esac_pkg::REG_LAT_LIMIT] = 32'(esac_pkg::RST_LAT_LIMIT);
      setting[esac_pkg::REG_GAIN]      = 32'(esac_pkg::RST_GAIN);
    end else begin
      cap = ($urandom_range(0, 3) == 0) ? 24'($urandom()) : 24'($urandom_range(256, 16384));
      setting[esac_pkg::REG_CAPACITY] = 32'(cap);
      setting[esac_pkg::REG_FLOOR] = ($urandom_range(0, 4) == 0)
                                     ? 32'(24'($urandom()))
                                     : 32'($urandom_range(0, cap));
      setting[esac_pkg::REG_LOW_ENE] = ($urandom_range(0, 3) == 0)
                                       ? 32'(24'($urandom()))
                                       : 32'($urandom_range(0, 2048));
      setting[esac_pkg::REG_FULL_ENE] = ($urandom_range(0, 3) == 0)
                                        ? 32'(24'($urandom()))
                                        : 32'($urandom_range(0, 2048));
      setting[esac_pkg::REG_LOW_LAT] = $urandom_range(0, 1)
                                       ? 32'(24'($urandom()))
                                       : 32'($urandom_range(0, 4096));
      setting[esac_pkg::REG_FULL_LAT] = $urandom_range(0, 1)
                                        ? 32'(24'($urandom()))
                                        : 32'($urandom_range(0, 4096));
      setting[esac_pkg::REG_LAT_LIMIT] = $urandom_range(0, 1)
                                         ? 32'(24'($urandom()))
                                         : 32'($urandom_range(0, 8192));
      setting[esac_pkg::REG_GAIN] = 32'($urandom_range(0, 65535));
    end
  endfunction

  // Offers one item, optionally after an idle burst, and waits until it is taken.
  // The valid stays high between back-to-back items.
  task automatic send_item(sample_t s);
    if (idle_in && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= s;
    do @(posedge clk); while (!in_tready);
    sb.note_item(s);
  endtask

  // Stops offering items and waits until every predicted result has come back, then
  // lets the pipeline run empty.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.pending_choices.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH) @(posedge clk);
  endtask

  // One APB write: a setup phase, then an access phase that completes on pready.
  // The select is left high so that writes can follow back to back.
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.set_reg(idx, val);
  endtask

  // Reloads all eight registers once the block has gone idle.
  task automatic load_settings();
    settle();
    for (int i = 0; i < 8; i++) begin
      write_reg(3'(i), setting[i]);
    end
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset values: capacity 20 J, floor 5 J, low 1.6 J, full 3.8 J, limit 18 s.
    send_item(sample_of(24'h0, 24'h0, 24'h0, 16'h0));                    // nothing fits
    send_item(sample_of(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 16'hFFFF)); // all ones
    send_item(sample_of(24'd1280, 24'd0, 24'd0, 16'd0));    // defer lands on the floor
    send_item(sample_of(24'd1279, 24'd0, 24'd0, 16'd0));    // one step below the floor
    send_item(sample_of(24'd1690, 24'd0, 24'd0, 16'd0));    // low power just fits
    send_item(sample_of(24'd2253, 24'd0, 24'd0, 16'd0));    // full power just fits
    send_item(sample_of(24'd1280, 24'd0, 24'd4608, 16'd0)); // age at the limit
    send_item(sample_of(24'd1280, 24'd0, 24'd4607, 16'd0)); // age one below the limit
    send_item(sample_of(24'd3000, 24'd0, 24'hFF_FF00, 16'd0)); // defer latency saturates
    send_item(sample_of(24'd3000, 24'd0, 24'hFF_FEFF, 16'd0)); // lands exactly on the top
    send_item(sample_of(24'd5120, 24'd0, 24'd0, 16'hFFFF));    // price makes inference dear
    send_item(sample_of(24'd0, 24'd2000, 24'd1000, 16'd16));   // harvest alone pays
    send_item(sample_of(24'd3000, 24'd0, 24'd1000, 16'h0100));
    send_item(sample_of(24'hAA_AAAA, 24'h55_5555, 24'hAA_AAAA, 16'h5555));
    send_item(sample_of(24'h55_5555, 24'hAA_AAAA, 24'h55_5555, 16'hAAAA));

    // Costs built to tie: at price 1.0 all three actions cost the same, so defer wins;
    // with an old task, low and full tie and low wins; a cheaper price favors full.
    setting[esac_pkg::REG_CAPACITY]  = 32'h00FF_FFFF;
    setting[esac_pkg::REG_FLOOR]     = 32'd0;
    setting[esac_pkg::REG_LOW_ENE]   = 32'd192;
    setting[esac_pkg::REG_FULL_ENE]  = 32'd256;
    setting[esac_pkg::REG_LOW_LAT]   = 32'd512;
    setting[esac_pkg::REG_FULL_LAT]  = 32'd512;
    setting[esac_pkg::REG_LAT_LIMIT] = 32'h00FF_FFFF;
    setting[esac_pkg::REG_GAIN]      = 32'd16384;
    load_settings();
    send_item(sample_of(24'd1000, 24'd0, 24'd256, 16'd256));
    send_item(sample_of(24'd1000, 24'd0, 24'd4096, 16'd256));
    send_item(sample_of(24'd1000, 24'd0, 24'd256, 16'd255));

    // Every register at its maximum.
    setting[esac_pkg::REG_CAPACITY]  = 32'h00FF_FFFF;
    setting[esac_pkg::REG_FLOOR]     = 32'h00FF_FFFF;
    setting[esac_pkg::REG_LOW_ENE]   = 32'h00FF_FFFF;
    setting[esac_pkg::REG_FULL_ENE]  = 32'h00FF_FFFF;
    setting[esac_pkg::REG_LOW_LAT]   = 32'h00FF_FFFF;
    setting[esac_pkg::REG_FULL_LAT]  = 32'h00FF_FFFF;
    setting[esac_pkg::REG_LAT_LIMIT] = 32'h00FF_FFFF;
    setting[esac_pkg::REG_GAIN]      = 32'h0000_FFFF;
    load_settings();
    send_item(sample_of(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 16'h0));
    send_item(sample_of(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 16'hFFFF));
    send_item(sample_of(24'h0, 24'h0, 24'h0, 16'h0));

    // Every register at zero, capacity included: projections clamp to zero.
    for (int i = 0; i < 8; i++) setting[i] = 32'd0;
    load_settings();
    send_item(sample_of(24'h0, 24'h0, 24'h0, 16'h0));
    send_item(sample_of(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 16'hFFFF));

    // Random phases, each under a fresh register set. Some phases run without idling,
    // and the last one never idles.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      random_setting();
      load_settings();
      idle_in = (ph != RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
      idle_out = (ph != RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_item(random_sample());
      end
    end

    settle();
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
